>>> rtl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Depends on nothing; define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// A property that must hold at every clock edge outside reset.
`define VPBD_ASSERT(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
// A condition that must be followed by another in the next cycle.
`define VPBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define VPBD_ASSERT(lbl, clk, rst_n, expr)
`define VPBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/vpbd_pkg.sv
// Shared types and constants of the pulse to byte decoder.
// Used by the controller, the datapath and the top level.
package vpbd_pkg;

	// Configuration register indexes and port widths.
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 8;
	localparam logic [CfgIdxW-1:0] RegSliceTicks = 2'd0;
	localparam logic [CfgIdxW-1:0] RegLineInverted = 2'd1;

	// Reset values of the configuration.
	localparam logic [7:0] SliceTicksReset = 8'd8;
	localparam logic LineInvertedReset = 1'b0;

	// Cell positions inside one group of ten.
	localparam logic [3:0] CellFirstMan = 4'd4;
	localparam logic [3:0] CellLast = 4'd9;
	localparam logic [3:0] CellWrapMan = 4'd14;
	localparam logic [7:0] TopBit = 8'h80;

	// Number of restoring division steps for an 8-bit duration.
	localparam int DivSteps = 8;

	typedef struct packed {
		logic frame_start;
		logic level;
		logic [7:0] duration;
	} in_item_t;

	typedef struct packed {
		logic byte_done;
		logic [7:0] data_byte;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ROUND,
		ST_CELLS,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic round_en;
		logic cell_step;
		logic emit;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_last;
		logic cells_zero;
		logic out_free;
	} stat_t;

endpackage

>>> rtl/van_pulse_byte_decoder.sv
// Top level of the pulse to byte decoder: joins controller and datapath.
// Depends on vpbd_pkg, vpbd_ctrl and vpbd_dp.
//
// Decodes enhanced Manchester line pulses into data bytes, one result item per
// pulse item. Each pulse passes in order through loading, eight steps of the
// restoring divider, rounding, one step per bit cell in the cell stepper (the
// cell count is the duration rounded to a whole number of slices), a check that
// sees the cell count run out and the write of the result register. The next
// pulse is taken while a result still waits at the output; the write of its own
// result then waits until the held one is taken.
module van_pulse_byte_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  vpbd_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output vpbd_pkg::out_item_t           out_item,
	input  logic                          cfg_we,
	input  logic [vpbd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [vpbd_pkg::CfgDataW-1:0] cfg_data
);
	import vpbd_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	vpbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	vpbd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.out_item  (out_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctrl      (ctrl),
		.stat      (stat)
	);

endmodule

>>> rtl/vpbd_ctrl.sv
// Controller state machine of the pulse to byte decoder.
// Depends on vpbd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vpbd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  vpbd_pkg::stat_t stat,
	output vpbd_pkg::ctrl_t ctrl
);
	import vpbd_pkg::*;

	state_t state_q;
	state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		ctrl = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_next = ST_DIV;
				end
			end
			ST_DIV: begin
				ctrl.div_step = 1'b1;
				if (stat.div_last) begin
					state_next = ST_ROUND;
				end
			end
			ST_ROUND: begin
				ctrl.round_en = 1'b1;
				state_next = ST_CELLS;
			end
			ST_CELLS: begin
				if (stat.cells_zero) begin
					state_next = ST_EMIT;
				end else begin
					ctrl.cell_step = 1'b1;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					ctrl.emit = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// An accepted item always starts the division.
	`VPBD_ASSERT_NEXT(a_load_div, clk, arst_n, ctrl.load, state_q == ST_DIV)
	// The division always hands over to rounding.
	`VPBD_ASSERT_NEXT(a_div_round, clk, arst_n, ctrl.div_step && stat.div_last,
		state_q == ST_ROUND)
	// Only one command is issued at a time.
	`VPBD_ASSERT(a_one_cmd, clk, arst_n, $onehot0(ctrl))

endmodule

>>> rtl/vpbd_dp.sv
// Datapath of the pulse to byte decoder: configuration, divider, cell stepper, result.
// Depends on vpbd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vpbd_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  vpbd_pkg::in_item_t                in_item,
	output vpbd_pkg::out_item_t               out_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	input  logic                              cfg_we,
	input  logic [vpbd_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [vpbd_pkg::CfgDataW-1:0]     cfg_data,
	input  vpbd_pkg::ctrl_t                   ctrl,
	output vpbd_pkg::stat_t                   stat
);
	import vpbd_pkg::*;

	logic [7:0] slice_q;
	logic       inv_q;

	logic       lvl_q;
	logic [7:0] dividend_q;
	logic [7:0] rem_q;
	logic [7:0] quot_q;
	logic [2:0] div_cnt_q;
	logic [7:0] cells_q;

	logic [3:0] pos_q;
	logic [7:0] partial_q;
	logic [7:0] sel_q;
	logic       done_q;
	logic [7:0] last_q;

	out_item_t  out_q;
	logic       out_valid_q;

	logic [8:0] trial;
	logic       ge;
	logic [8:0] trial_diff;
	logic [7:0] round_diff;
	logic       round_up;
	logic [8:0] cells_sum;
	logic       manchester;
	logic [3:0] pos_inc;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q <= SliceTicksReset;
			inv_q <= LineInvertedReset;
		end else if (cfg_we) begin
			case (cfg_index)
				RegSliceTicks: slice_q <= cfg_data[7:0];
				RegLineInverted: inv_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// One restoring division step and the final round to nearest, ties down.
	always_comb begin
		trial = {rem_q, dividend_q[7]};
		ge = trial >= {1'b0, slice_q};
		trial_diff = trial - {1'b0, slice_q};
		round_diff = slice_q - rem_q;
		round_up = (rem_q != 8'd0) && (round_diff < rem_q);
		cells_sum = {1'b0, quot_q} + {8'd0, round_up};
		pos_inc = pos_q + 4'd1;
		manchester = pos_q inside {CellFirstMan, CellLast, CellWrapMan};
	end

	// Division registers and the cell count.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			lvl_q <= in_item.level ^ inv_q;
			dividend_q <= in_item.duration;
			rem_q <= 8'd0;
			quot_q <= 8'd0;
			div_cnt_q <= 3'd0;
		end else if (ctrl.div_step) begin
			rem_q <= ge ? trial_diff[7:0] : trial[7:0];
			dividend_q <= {dividend_q[6:0], 1'b0};
			quot_q <= {quot_q[6:0], ge};
			div_cnt_q <= div_cnt_q + 3'd1;
		end
		if (ctrl.round_en) begin
			cells_q <= (slice_q == 8'd0) ? 8'd0 : cells_sum[7:0];
		end else if (ctrl.cell_step) begin
			cells_q <= cells_q - 8'd1;
		end
	end

	// Decoder state: cell position, partial byte and bit mask.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 4'd0;
			partial_q <= 8'd0;
			sel_q <= TopBit;
			done_q <= 1'b0;
			last_q <= 8'd0;
		end else if (ctrl.load) begin
			done_q <= 1'b0;
			last_q <= 8'd0;
			if (in_item.frame_start) begin
				pos_q <= 4'd0;
				partial_q <= 8'd0;
				sel_q <= TopBit;
			end
		end else if (ctrl.cell_step) begin
			if (!manchester) begin
				if (lvl_q) begin
					partial_q <= partial_q | sel_q;
				end
				sel_q <= sel_q >> 1;
				pos_q <= pos_inc;
			end else if (pos_q == CellLast) begin
				last_q <= partial_q;
				done_q <= 1'b1;
				partial_q <= 8'd0;
				sel_q <= TopBit;
				pos_q <= 4'd0;
			end else begin
				pos_q <= pos_inc;
			end
		end
	end

	// Result register; it holds until the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			out_q.byte_done <= done_q;
			out_q.data_byte <= done_q ? last_q : 8'd0;
		end
	end

	assign out_item = out_q;
	assign out_valid = out_valid_q;
	assign stat.div_last = (div_cnt_q == 3'(DivSteps - 1));
	assign stat.cells_zero = (cells_q == 8'd0);
	assign stat.out_free = !out_valid_q || !out_stall;

	// The bit mask is one-hot or exhausted.
	`VPBD_ASSERT(a_sel_onehot, clk, arst_n, $onehot0(sel_q))
	// The cell position never leaves the group of ten.
	`VPBD_ASSERT(a_pos_range, clk, arst_n, pos_q <= CellLast)
	// A result is shown right after it is written.
	`VPBD_ASSERT_NEXT(a_emit_valid, clk, arst_n, ctrl.emit, out_valid_q)

endmodule
